// ----- rtl/svalloc_pkg.sv -----
// Package for the voice allocator: slot kind codes, slot record layout and field widths.
// Used by the channel interfaces and by the top level; depends on nothing.
package svalloc_pkg;

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASED = 2'd0,
    KIND_PRESSED  = 2'd1,
    KIND_HELD     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } slot_t;

  localparam slot_t SLOT_RESET = '{kind: KIND_RELEASED, note: '0, vel: '0};

endpackage

// ----- rtl/svalloc_if.sv -----
// Valid/ready channel interfaces of the voice allocator: key requests, voice requests
// and the mode register write channel. Depends on svalloc_pkg.
interface svalloc_key_if;
  logic                            valid;
  logic                            ready;
  logic                            event_kind;
  logic [svalloc_pkg::NOTE_W-1:0]  note_number;
  logic [svalloc_pkg::VEL_W-1:0]   key_velocity;

  modport source (output valid, event_kind, note_number, key_velocity, input ready);
  modport sink   (input valid, event_kind, note_number, key_velocity, output ready);
endinterface

interface svalloc_voice_if #(
  parameter int IDX_W = 3
);
  logic                            valid;
  logic                            ready;
  logic [IDX_W-1:0]                voice_index;
  logic [svalloc_pkg::KIND_W-1:0]  out_kind;
  logic [svalloc_pkg::NOTE_W-1:0]  out_note;
  logic [svalloc_pkg::VEL_W-1:0]   out_velocity;

  modport source (output valid, voice_index, out_kind, out_note, out_velocity, input ready);
  modport sink   (input valid, voice_index, out_kind, out_note, out_velocity, output ready);
endinterface

interface svalloc_cfg_if;
  logic valid;
  logic ready;
  logic mono_mode;

  modport source (output valid, mono_mode, input ready);
  modport sink   (input valid, mono_mode, output ready);
endinterface

// ----- rtl/synth_voice_allocator_unit.sv -----
// Top level of the synthesizer voice allocator: slot memory, scan sequencer and output register.
// Depends on svalloc_pkg and the channel interfaces in svalloc_if.sv.
//
// Each key request is taken only when the allocator is idle. For each request the allocator
// reads every slot through the single registered read port of the slot memory, evaluates the
// last slot read, writes back on the single write port in ST_DECIDE and, for a second slot, in
// ST_WR2, loads any voice request into the output register in ST_FINISH, then returns to idle.
// The load waits while an earlier voice request still sits unaccepted in the output register.
// A finished voice request waits in that register while the next key request is accepted.
// Slots come out of reset released through per-slot valid bits, so no clearing pass is run.
// The user must see that the mode register is written through cfg_i only while the allocator
// is idle; the block does not enforce this. cfg_i is always ready. The voice_o interface
// must be instantiated with IDX_W = $clog2(NUM_VOICES).
module synth_voice_allocator_unit #(
  parameter int NUM_VOICES = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  svalloc_cfg_if.sink       cfg_i,
  svalloc_key_if.sink       key_i,
  svalloc_voice_if.source   voice_o
);
  import svalloc_pkg::*;

  localparam int IdxW = $clog2(NUM_VOICES);
  localparam int CntW = $clog2(NUM_VOICES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VOICES - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(NUM_VOICES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WR2,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     cnt_q;
  logic                rv_q;
  logic [IdxW-1:0]     rd_idx_q;
  slot_t               rdata_q;
  slot_t               mem_q [NUM_VOICES];
  logic [NUM_VOICES-1:0] vld_q;
  logic                mono_q;
  logic [IdxW-1:0]     next_slot_q;

  logic                req_press_q;
  logic [NOTE_W-1:0]   req_note_q;
  logic [VEL_W-1:0]    req_vel_q;

  logic                m_found_q, hi_found_q, lo_found_q, park_found_q, best_found_q;
  logic [IdxW-1:0]     m_idx_q, hi_idx_q, lo_idx_q, park_idx_q, best_idx_q;
  logic [NOTE_W-1:0]   best_note_q;
  logic [VEL_W-1:0]    best_vel_q;
  slot_t               s0_q;

  logic                w2_en_q;
  logic [IdxW-1:0]     w2_addr_q;
  slot_t               w2_data_q;
  logic                res_en_q;
  logic [IdxW-1:0]     res_idx_q;
  kind_e               res_kind_q;
  logic [NOTE_W-1:0]   res_note_q;
  logic [VEL_W-1:0]    res_vel_q;

  logic                out_valid_q;
  logic [IdxW-1:0]     out_idx_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [NOTE_W-1:0]   out_note_q;
  logic [VEL_W-1:0]    out_vel_q;

  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  slot_t               entry;
  logic                note_eq, is_match;
  logic                out_load;

  logic                w1_en, w2_en, res_en, ns_en;
  logic [IdxW-1:0]     w1_addr, w2_addr, res_idx, ns_val, press_idx;
  slot_t               w1_data, w2_data;
  kind_e               res_kind;
  logic [NOTE_W-1:0]   res_note;
  logic [VEL_W-1:0]    res_vel;

  logic                mem_we;
  logic [IdxW-1:0]     mem_wa;
  slot_t               mem_wd;

  assign key_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign voice_o.valid        = out_valid_q;
  assign voice_o.voice_index  = out_idx_q;
  assign voice_o.out_kind     = out_kind_q;
  assign voice_o.out_note     = out_note_q;
  assign voice_o.out_velocity = out_vel_q;

  assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CntEnd);
  assign rd_addr = cnt_q[IdxW-1:0];

  assign out_load = (state_q == ST_FINISH) && res_en_q && (!out_valid_q || voice_o.ready);

  // Slots never written read as released.
  assign entry    = vld_q[rd_idx_q] ? rdata_q : SLOT_RESET;
  assign note_eq  = (entry.note == req_note_q);
  assign is_match = note_eq && (mono_q ? (entry.kind != KIND_RELEASED)
                                       : (entry.kind == KIND_PRESSED));

  always_comb begin
    w1_en     = 1'b0;
    w1_addr   = '0;
    w1_data   = SLOT_RESET;
    w2_en     = 1'b0;
    w2_addr   = '0;
    w2_data   = SLOT_RESET;
    res_en    = 1'b0;
    res_idx   = '0;
    res_kind  = KIND_RELEASED;
    res_note  = req_note_q;
    res_vel   = req_vel_q;
    ns_en     = 1'b0;
    ns_val    = '0;
    press_idx = next_slot_q;
    if (m_found_q) begin
      press_idx = m_idx_q;
    end else if (hi_found_q) begin
      press_idx = hi_idx_q;
    end else if (lo_found_q) begin
      press_idx = lo_idx_q;
    end
    if (!mono_q) begin
      if (req_press_q) begin
        w1_en    = 1'b1;
        w1_addr  = press_idx;
        w1_data  = '{kind: KIND_PRESSED, note: req_note_q, vel: req_vel_q};
        res_en   = 1'b1;
        res_idx  = press_idx;
        res_kind = KIND_PRESSED;
        if (!m_found_q) begin
          ns_en  = 1'b1;
          ns_val = (press_idx == LastIdx) ? '0 : press_idx + 1'b1;
        end
      end else if (m_found_q) begin
        w1_en    = 1'b1;
        w1_addr  = m_idx_q;
        w1_data  = '{kind: KIND_RELEASED, note: req_note_q, vel: req_vel_q};
        res_en   = 1'b1;
        res_idx  = m_idx_q;
        res_kind = KIND_RELEASED;
      end
    end else if (req_press_q) begin
      if (s0_q.kind == KIND_PRESSED || s0_q.kind == KIND_HELD) begin
        if (s0_q.note < req_note_q) begin
          w1_en    = park_found_q;
          w1_addr  = park_idx_q;
          w1_data  = '{kind: KIND_HELD, note: s0_q.note, vel: s0_q.vel};
          w2_en    = 1'b1;
          w2_data  = '{kind: KIND_HELD, note: req_note_q, vel: req_vel_q};
          res_en   = 1'b1;
          res_kind = KIND_HELD;
        end else if (s0_q.note > req_note_q) begin
          w1_en   = park_found_q;
          w1_addr = park_idx_q;
          w1_data = '{kind: KIND_HELD, note: req_note_q, vel: req_vel_q};
        end
      end else begin
        w1_en    = 1'b1;
        w1_data  = '{kind: KIND_PRESSED, note: req_note_q, vel: req_vel_q};
        res_en   = 1'b1;
        res_kind = KIND_PRESSED;
      end
    end else if (m_found_q) begin
      if (m_idx_q == '0) begin
        res_en = 1'b1;
        if (best_found_q) begin
          w1_en    = 1'b1;
          w1_addr  = best_idx_q;
          w1_data  = '{kind: KIND_RELEASED, note: best_note_q, vel: best_vel_q};
          w2_en    = 1'b1;
          w2_data  = '{kind: KIND_HELD, note: best_note_q, vel: best_vel_q};
          res_kind = KIND_HELD;
          res_note = best_note_q;
          res_vel  = best_vel_q;
        end else begin
          w1_en    = 1'b1;
          w1_data  = '{kind: KIND_RELEASED, note: req_note_q, vel: req_vel_q};
          res_kind = KIND_RELEASED;
        end
      end else begin
        w1_en   = 1'b1;
        w1_addr = m_idx_q;
        w1_data = '{kind: KIND_RELEASED, note: req_note_q, vel: req_vel_q};
      end
    end
  end

  assign mem_we = ((state_q == ST_DECIDE) && w1_en) || ((state_q == ST_WR2) && w2_en_q);
  assign mem_wa = (state_q == ST_WR2) ? w2_addr_q : w1_addr;
  assign mem_wd = (state_q == ST_WR2) ? w2_data_q : w1_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rv_q         <= 1'b0;
      rd_idx_q     <= '0;
      vld_q        <= '0;
      mono_q       <= 1'b0;
      next_slot_q  <= '0;
      req_press_q  <= 1'b0;
      req_note_q   <= '0;
      req_vel_q    <= '0;
      m_found_q    <= 1'b0;
      hi_found_q   <= 1'b0;
      lo_found_q   <= 1'b0;
      park_found_q <= 1'b0;
      best_found_q <= 1'b0;
      m_idx_q      <= '0;
      hi_idx_q     <= '0;
      lo_idx_q     <= '0;
      park_idx_q   <= '0;
      best_idx_q   <= '0;
      best_note_q  <= '0;
      best_vel_q   <= '0;
      s0_q         <= SLOT_RESET;
      w2_en_q      <= 1'b0;
      w2_addr_q    <= '0;
      w2_data_q    <= SLOT_RESET;
      res_en_q     <= 1'b0;
      res_idx_q    <= '0;
      res_kind_q   <= KIND_RELEASED;
      res_note_q   <= '0;
      res_vel_q    <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_kind_q   <= '0;
      out_note_q   <= '0;
      out_vel_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        mono_q <= cfg_i.mono_mode;
      end
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && voice_o.ready) begin
        out_valid_q <= 1'b0;
      end
      rv_q     <= rd_en;
      rd_idx_q <= rd_addr;
      case (state_q)
        ST_IDLE: begin
          if (key_i.valid) begin
            req_press_q  <= key_i.event_kind;
            req_note_q   <= key_i.note_number;
            req_vel_q    <= key_i.key_velocity;
            cnt_q        <= '0;
            m_found_q    <= 1'b0;
            hi_found_q   <= 1'b0;
            lo_found_q   <= 1'b0;
            park_found_q <= 1'b0;
            best_found_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rv_q) begin
            if (is_match && !m_found_q) begin
              m_found_q <= 1'b1;
              m_idx_q   <= rd_idx_q;
            end
            if (entry.kind != KIND_PRESSED) begin
              if (rd_idx_q >= next_slot_q && !hi_found_q) begin
                hi_found_q <= 1'b1;
                hi_idx_q   <= rd_idx_q;
              end
              if (rd_idx_q < next_slot_q && !lo_found_q) begin
                lo_found_q <= 1'b1;
                lo_idx_q   <= rd_idx_q;
              end
            end
            if (rd_idx_q == '0) begin
              s0_q <= entry;
            end else begin
              if (entry.kind == KIND_RELEASED && !park_found_q) begin
                park_found_q <= 1'b1;
                park_idx_q   <= rd_idx_q;
              end
              if (entry.kind == KIND_HELD && (!best_found_q || entry.note > best_note_q)) begin
                best_found_q <= 1'b1;
                best_idx_q   <= rd_idx_q;
                best_note_q  <= entry.note;
                best_vel_q   <= entry.vel;
              end
            end
          end
          if (cnt_q == CntEnd) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          w2_en_q    <= w2_en;
          w2_addr_q  <= w2_addr;
          w2_data_q  <= w2_data;
          res_en_q   <= res_en;
          res_idx_q  <= res_idx;
          res_kind_q <= res_kind;
          res_note_q <= res_note;
          res_vel_q  <= res_vel;
          if (ns_en) begin
            next_slot_q <= ns_val;
          end
          state_q <= w2_en ? ST_WR2 : ST_FINISH;
        end
        ST_WR2: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!res_en_q) begin
            state_q <= ST_IDLE;
          end else if (out_load) begin
            out_idx_q   <= res_idx_q;
            out_kind_q  <= res_kind_q;
            out_note_q  <= res_note_q;
            out_vel_q   <= res_vel_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_next_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= LastIdx)
    else $error("round-robin pointer out of range");

  a_held_on_voice0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_HELD) |-> (out_idx_q == '0))
    else $error("held request not on voice 0");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("slot write during scan");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_kind_q != 2'd3))
    else $error("invalid request kind");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for synth_voice_allocator_unit: a directed table of key requests, then random ones.
// Voice requests are checked against a behavioral allocator kept in step with accepted requests.
// Depends on svalloc_pkg, the channel interfaces in svalloc_if.sv and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svalloc_pkg::*;

  localparam int NUM_VOICES   = 6;
  localparam int IDX_W        = $clog2(NUM_VOICES);
  localparam int CLK_PERIOD   = 10;
  localparam int DRAIN_CYCLES = 24;
  localparam int RAND_ITEMS   = 1250;
  localparam int PHASES       = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int LIMIT_CYCLES = 800000;
  localparam int DIR_ROWS     = 26;

  typedef enum logic {MODE_POLY = 1'b0, MODE_MONO = 1'b1} mode_e;
  typedef enum logic {EV_RELEASE = 1'b0, EV_PRESS = 1'b1} event_e;
  typedef enum logic {ROW_KEY = 1'b0, ROW_CFG = 1'b1} row_op_e;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    kind_e             kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } voice_req_t;

  typedef struct packed {
    row_op_e           op;
    mode_e             mode;
    event_e            ev;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              typed;
    voice_req_t        want;
  } stim_row_t;

  localparam voice_req_t NO_REQ = '0;

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_CFG, MODE_MONO, EV_RELEASE, 7'd0,   7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd64,  7'd127, 1'b1, '{3'd0, KIND_PRESSED, 7'd64, 7'd127}},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd64,  7'd3,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd70,  7'd10,  1'b1, '{3'd0, KIND_HELD, 7'd70, 7'd10}},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd50,  7'd40,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd64,  7'd20,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_RELEASE, 7'd50,  7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_RELEASE, 7'd99,  7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_RELEASE, 7'd70,  7'd1,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd30,  7'd9,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd31,  7'd9,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd32,  7'd9,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd33,  7'd9,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd0,   7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_MONO, EV_PRESS,   7'd127, 7'd127, 1'b1, '{3'd0, KIND_HELD, 7'd127, 7'd127}},
    '{ROW_CFG, MODE_POLY, EV_RELEASE, 7'd0,   7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd127, 7'd0,   1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd0,   7'd127, 1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd2,   7'd64,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd3,   7'd64,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd4,   7'd64,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd6,   7'd64,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd9,   7'd85,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_RELEASE, 7'd0,   7'd42,  1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_RELEASE, 7'd99,  7'd127, 1'b0, NO_REQ},
    '{ROW_KEY, MODE_POLY, EV_PRESS,   7'd3,   7'd50,  1'b0, NO_REQ}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  svalloc_cfg_if                    cfg_ch ();
  svalloc_key_if                    key_ch ();
  svalloc_voice_if #(.IDX_W(IDX_W)) voice_ch ();

  synth_voice_allocator_unit #(
    .NUM_VOICES(NUM_VOICES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .key_i  (key_ch),
    .voice_o(voice_ch)
  );

  slot_t      slot_mem [NUM_VOICES] = '{default: SLOT_RESET};
  int         rr_ptr = 0;
  mode_e      mode_reg = MODE_POLY;
  voice_req_t voice_exp_q [$];
  int         err_count = 0;
  logic       typed_valid = 1'b0;
  voice_req_t typed_req = '0;
  bit         calm_phase = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string req_text(input voice_req_t r);
    return $sformatf("voice %0d kind %0d note %0d vel %0d", r.idx, r.kind, r.note, r.vel);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  function automatic int free_park_slot();
    for (int i = 1; i < NUM_VOICES; i++)
      if (slot_mem[i].kind == KIND_RELEASED) return i;
    return NUM_VOICES;
  endfunction

  function automatic bit route_key(input event_e ev, input logic [NOTE_W-1:0] note,
                                   input logic [VEL_W-1:0] vel, output voice_req_t req);
    int park;
    int idx;
    int best;
    req = '0;
    if (mode_reg == MODE_POLY) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (slot_mem[i].kind == KIND_PRESSED && slot_mem[i].note == note) begin
          slot_mem[i] = '{(ev == EV_PRESS) ? KIND_PRESSED : KIND_RELEASED, note, vel};
          req = '{i[IDX_W-1:0], slot_mem[i].kind, note, vel};
          return 1'b1;
        end
      end
      if (ev == EV_RELEASE) return 1'b0;
      idx = rr_ptr;
      for (int n = 0; n < NUM_VOICES && slot_mem[idx].kind == KIND_PRESSED; n++)
        idx = (idx + 1) % NUM_VOICES;
      slot_mem[idx] = '{KIND_PRESSED, note, vel};
      rr_ptr = (idx + 1) % NUM_VOICES;
      req = '{idx[IDX_W-1:0], KIND_PRESSED, note, vel};
      return 1'b1;
    end
    if (ev == EV_PRESS) begin
      if (slot_mem[0].kind != KIND_RELEASED) begin
        park = free_park_slot();
        if (slot_mem[0].note < note) begin
          if (park < NUM_VOICES) slot_mem[park] = '{KIND_HELD, slot_mem[0].note, slot_mem[0].vel};
          slot_mem[0] = '{KIND_HELD, note, vel};
          req = '{'0, KIND_HELD, note, vel};
          return 1'b1;
        end
        if (slot_mem[0].note > note && park < NUM_VOICES) slot_mem[park] = '{KIND_HELD, note, vel};
        return 1'b0;
      end
      slot_mem[0] = '{KIND_PRESSED, note, vel};
      req = '{'0, KIND_PRESSED, note, vel};
      return 1'b1;
    end
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (slot_mem[i].kind != KIND_RELEASED && slot_mem[i].note == note) begin
        if (i != 0) begin
          slot_mem[i] = '{KIND_RELEASED, note, vel};
          return 1'b0;
        end
        best = NUM_VOICES;
        for (int j = 1; j < NUM_VOICES; j++)
          if (slot_mem[j].kind == KIND_HELD &&
              (best == NUM_VOICES || slot_mem[j].note > slot_mem[best].note))
            best = j;
        if (best < NUM_VOICES) begin
          req = '{'0, KIND_HELD, slot_mem[best].note, slot_mem[best].vel};
          slot_mem[best].kind = KIND_RELEASED;
          slot_mem[0] = '{KIND_HELD, req.note, req.vel};
          return 1'b1;
        end
        slot_mem[0] = '{KIND_RELEASED, note, vel};
        req = '{'0, KIND_RELEASED, note, vel};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    voice_req_t got;
    voice_req_t want;
    voice_req_t fresh;
    bit         hit;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) mode_reg = mode_e'(cfg_ch.mono_mode);
      if (voice_ch.valid && voice_ch.ready) begin
        got.idx  = voice_ch.voice_index;
        got.kind = kind_e'(voice_ch.out_kind);
        got.note = voice_ch.out_note;
        got.vel  = voice_ch.out_velocity;
        if (voice_exp_q.size() == 0) begin
          flag_error($sformatf("unexpected voice request: %s", req_text(got)));
        end else begin
          want = voice_exp_q.pop_front();
          if (got.idx !== want.idx || got.kind !== want.kind ||
              got.note !== want.note || got.vel !== want.vel)
            flag_error($sformatf("voice request mismatch: expected %s, got %s",
                                 req_text(want), req_text(got)));
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        hit = route_key(event_e'(key_ch.event_kind), key_ch.note_number,
                        key_ch.key_velocity, fresh);
        if (typed_valid) begin
          fresh = typed_req;
          hit   = 1'b1;
        end
        if (hit) voice_exp_q.push_back(fresh);
      end
    end
  end

  initial begin
    int stall;
    voice_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm_phase ? 0 : pick_gap();
      if (stall > 0) begin
        voice_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      voice_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  task automatic send_key(input event_e ev, input logic [NOTE_W-1:0] note,
                          input logic [VEL_W-1:0] vel, input logic typed,
                          input voice_req_t want);
    key_ch.valid        <= 1'b1;
    key_ch.event_kind   <= ev;
    key_ch.note_number  <= note;
    key_ch.key_velocity <= vel;
    typed_valid         <= typed;
    typed_req           <= want;
    do @(posedge clk); while (!key_ch.ready);
    @(negedge clk);
  endtask

  // hold requests off; with drain, wait out every pending voice request and the scan behind it
  task automatic rest_keys(input int cycles, input bit drain);
    key_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
    if (drain) begin
      while (voice_exp_q.size() != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
  endtask

  task automatic write_mode(input mode_e m);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.mono_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int                gap;
    int                base;
    logic [NOTE_W-1:0] note;
    event_e            ev;
    bit                down [128];
    cfg_ch.valid        = 1'b0;
    cfg_ch.mono_mode    = 1'b0;
    key_ch.valid        = 1'b0;
    key_ch.event_kind   = 1'b0;
    key_ch.note_number  = '0;
    key_ch.key_velocity = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].op == ROW_CFG) begin
        if (r != 0) rest_keys(0, 1'b1);
        write_mode(DIR_TABLE[r].mode);
      end else begin
        send_key(DIR_TABLE[r].ev, DIR_TABLE[r].note, DIR_TABLE[r].vel,
                 DIR_TABLE[r].typed, DIR_TABLE[r].want);
        gap = pick_gap();
        if (gap > 0) rest_keys(gap, 1'b0);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      rest_keys(0, 1'b1);
      write_mode((ph == 0) ? MODE_POLY : (ph == 1) ? MODE_MONO : mode_e'($urandom_range(0, 1)));
      calm_phase = ($urandom_range(0, 3) == 0);
      base = $urandom_range(0, 116);
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          note = NOTE_W'(base + $urandom_range(0, 11));
          if (!down[note]) ev = EV_PRESS;
          else ev = ($urandom_range(0, 4) == 0) ? EV_PRESS : EV_RELEASE;
        end else begin
          note = NOTE_W'($urandom_range(0, 127));
          ev   = event_e'($urandom_range(0, 1));
        end
        down[note] = (ev == EV_PRESS);
        send_key(ev, note, VEL_W'($urandom_range(0, 127)), 1'b0, NO_REQ);
        if ($urandom_range(0, 39) == 0) begin
          rest_keys(0, 1'b1);
        end else begin
          gap = calm_phase ? 0 : pick_gap();
          if (gap > 0) rest_keys(gap, 1'b0);
        end
      end
    end

    rest_keys(0, 1'b1);
    if (err_count == 0 && voice_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
